>>> rtl/breakpoint_address_table_top_macros.svh
// Assertion macros for the breakpoint address table.
// Included by files that carry concurrent assertions; depends on nothing.
`ifndef BREAKPOINT_ADDRESS_TABLE_TOP_MACROS_SVH
`define BREAKPOINT_ADDRESS_TABLE_TOP_MACROS_SVH
`ifndef ASSERT_OFF
`define BAT_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define BAT_ASSERT_NORST(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define BAT_ASSERT(lbl, clk, rst_n, prop, msg)
`define BAT_ASSERT_NORST(lbl, clk, prop, msg)
`endif
`endif

>>> rtl/bat_pkg.sv
// Shared types and constants for the breakpoint address table.
// Used by bat_ctrl, bat_dp and breakpoint_address_table_top.
package bat_pkg;

  localparam int ADDR_W = 16;
  localparam int CNT_W  = 4;

  localparam logic [1:0] OP_ADD    = 2'd0;
  localparam logic [1:0] OP_REMOVE = 2'd1;
  localparam logic [1:0] OP_QUERY  = 2'd2;

  typedef struct packed {
    logic [1:0]        op;
    logic [ADDR_W-1:0] address;
    logic [CNT_W-1:0]  position;
  } in_item_t;

  typedef struct packed {
    logic             ok;
    logic             hit;
    logic [CNT_W-1:0] entry_count;
  } out_item_t;

  // controller to datapath
  typedef struct packed {
    logic load_item;
    logic execute;
  } dp_cmd_t;

  // datapath to the top-level checks
  typedef struct packed {
    logic [CNT_W-1:0] count;
  } dp_status_t;

endpackage

>>> rtl/bat_ctrl.sv
// Controller for the breakpoint address table: sequences capture and execute
// of one transaction at a time and owns the result valid. Depends on bat_pkg.
module bat_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  output logic             out_valid,
  input  logic             out_stall,
  output bat_pkg::dp_cmd_t cmd
);

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   slot_free;

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign slot_free = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    cmd.load_item = 1'b0;
    cmd.execute   = 1'b0;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_item = 1'b1;
          state_nxt     = S_EXEC;
        end
      end
      S_EXEC: begin
        // hold the item until the output register can take its result
        if (slot_free) begin
          cmd.execute   = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

>>> rtl/bat_dp.sv
// Datapath for the breakpoint address table: item register, entry registers
// with per-entry comparators and neighbour shift, live count and result register.
// Depends on bat_pkg.
module bat_dp #(
  parameter int MAX_ENTRIES = 8
) (
  input  logic                clk,
  input  logic                rst_n,
  input  bat_pkg::in_item_t   in_data,
  input  bat_pkg::dp_cmd_t    cmd,
  output bat_pkg::out_item_t  out_data,
  output bat_pkg::dp_status_t status
);

  localparam int CW = bat_pkg::CNT_W;
  localparam int AW = bat_pkg::ADDR_W;

  bat_pkg::in_item_t  item_r;
  bat_pkg::out_item_t result_r, result_nxt;
  logic [AW-1:0]      entries_r   [MAX_ENTRIES];
  logic [AW-1:0]      entries_nxt [MAX_ENTRIES];
  logic [CW-1:0]      count_r, count_nxt;
  logic [MAX_ENTRIES-1:0] match;
  logic               hit;
  logic               has_room;
  logic               pos_ok;

  always_comb begin
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      match[i] = (CW'(i) < count_r) && (entries_r[i] == item_r.address);
    end
  end

  assign hit      = |match;
  assign has_room = (count_r < CW'(MAX_ENTRIES));
  assign pos_ok   = (item_r.position != '0) && (item_r.position <= count_r);

  always_comb begin
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      entries_nxt[i] = entries_r[i];
    end
    count_nxt              = count_r;
    result_nxt.ok          = 1'b0;
    result_nxt.hit         = 1'b0;
    unique case (item_r.op)
      bat_pkg::OP_ADD: begin
        if (hit) begin
          result_nxt.ok  = 1'b1;
          result_nxt.hit = 1'b1;
        end else if (has_room) begin
          for (int i = 0; i < MAX_ENTRIES; i++) begin
            if (CW'(i) == count_r) begin
              entries_nxt[i] = item_r.address;
            end
          end
          count_nxt     = count_r + 1'b1;
          result_nxt.ok = 1'b1;
        end
      end
      bat_pkg::OP_REMOVE: begin
        if (pos_ok) begin
          // shift every entry after the removed slot down one place
          for (int i = 0; i < MAX_ENTRIES - 1; i++) begin
            if (CW'(i + 1) >= item_r.position) begin
              entries_nxt[i] = entries_r[i + 1];
            end
          end
          count_nxt     = count_r - 1'b1;
          result_nxt.ok = 1'b1;
        end
      end
      bat_pkg::OP_QUERY: begin
        result_nxt.hit = hit;
      end
      default: begin
      end
    endcase
    result_nxt.entry_count = count_nxt;
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      item_r <= in_data;
    end
    if (cmd.execute) begin
      result_r <= result_nxt;
      for (int i = 0; i < MAX_ENTRIES; i++) begin
        entries_r[i] <= entries_nxt[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (cmd.execute) begin
      count_r <= count_nxt;
    end
  end

  assign out_data     = result_r;
  assign status.count = count_r;

endmodule

>>> rtl/breakpoint_address_table_top.sv
// Breakpoint address table, top level. An accepted transaction is first
// captured, then executed (compare/shift of all entries in parallel) into the
// result register; no new transaction is taken until it executes, and it waits
// while the result register is stalled. Synchronous active-low reset empties
// the table and drops any pending result; entry contents are not cleared.
`include "breakpoint_address_table_top_macros.svh"
module breakpoint_address_table_top #(
  parameter int MAX_ENTRIES = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  bat_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output bat_pkg::out_item_t out_data
);

  bat_pkg::dp_cmd_t    cmd;
  bat_pkg::dp_status_t dp_status;

  bat_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  bat_dp #(
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .cmd      (cmd),
    .out_data (out_data),
    .status   (dp_status)
  );

  `BAT_ASSERT(a_count_max, clk, rst_n, dp_status.count <= MAX_ENTRIES, "count above capacity")
  `BAT_ASSERT(a_count_step, clk, rst_n, !cmd.execute |=> $stable(dp_status.count), "count moved")
  `BAT_ASSERT(a_no_load_exec, clk, rst_n, !(cmd.load_item && cmd.execute), "load and execute")
  `BAT_ASSERT_NORST(a_rst_empty, clk, !rst_n |=> !out_valid && dp_status.count == 0, "dirty reset")

endmodule
